>>> rtl/core/clmt_pkg.sv
`timescale 1ns / 1ps

package clmt_pkg;

    // Field widths of the stream and configuration ports.
    localparam int IDX_IN_W = 10;
    localparam int LABEL_W  = 10;
    localparam int CFG_W    = 11;
    localparam int ACT_W    = 3;
    localparam int TDATA_W  = 24;

    // Default table size handed to the top level.
    localparam int ENTRIES_DEF = 1024;

    // Largest label; the allocator saturates here.
    localparam logic [LABEL_W-1:0] LABEL_MAX = '1;

    // Request kinds carried on the input tuser bit.
    localparam logic CMD_MERGE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Outcome of a request, carried on the output tuser bits.
    typedef enum logic [ACT_W-1:0] {
        ACT_NEW      = 3'd0,
        ACT_B_JOINED = 3'd1,
        ACT_A_JOINED = 3'd2,
        ACT_RELABEL  = 3'd3,
        ACT_NONE     = 3'd4
    } t_action;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic red_step;
        logic rd_a;
        logic rd_b;
        logic dec;
        logic wr_a;
        logic wr_b;
        logic scan_step;
        logic clr_step;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic    red_last;
        logic    clr_last;
        logic    scan_done;
        logic    out_free;
        t_action act_now;
        t_action act_reg;
    } t_dp_st;

endpackage

>>> rtl/core/cluster_label_merge_table.sv
// A request takes index reduction modulo ENTRIES when ENTRIES < 1024, then reads of the
// labels of A and B, the case decision, table writes or a scan, and the output register.
// A relabel of two distinct clusters walks the first min(entries_in_use, ENTRIES, 1024)
// entries of the table through one read port; one request in flight, none taken until the
// result is loaded. Reset is synchronous, active low; afterwards a clearing pass zeroes all
// min(ENTRIES, 1024) entries before the first request; configuration writes are taken always.
`timescale 1ns / 1ps

module cluster_label_merge_table import clmt_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration: entries_in_use.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_data,
    // Request stream.
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [TDATA_W-1:0] i_s_axis_tdata,  // index_a[9:0], index_b[19:10], zeros
    input  logic               i_s_axis_tuser,  // cmd
    // Result stream.
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata,  // label_a[9:0], label_b[19:10], zeros
    output logic [ACT_W-1:0]   o_m_axis_tuser   // action
);

    t_dp_cmd cmd;
    t_dp_st  st;

    assign o_cfg_ready = 1'b1;

    clmt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_st      (st),
        .o_cmd     (cmd)
    );

    clmt_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tuser   (o_m_axis_tuser)
    );

endmodule

>>> rtl/core/clmt_ctrl.sv
`timescale 1ns / 1ps

module clmt_ctrl import clmt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    output logic    o_s_ready,
    input  t_dp_st  i_st,
    output t_dp_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_CLR  = 10'b00_0000_0001,
        S_IDLE = 10'b00_0000_0010,
        S_RED  = 10'b00_0000_0100,
        S_RDA  = 10'b00_0000_1000,
        S_RDB  = 10'b00_0001_0000,
        S_DEC  = 10'b00_0010_0000,
        S_WRA  = 10'b00_0100_0000,
        S_WRB  = 10'b00_1000_0000,
        S_SCAN = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_ready = (r_state == S_IDLE);

    // Next state and per-state commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_st.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RED;
                end
            end
            S_RED: begin
                o_cmd.red_step = 1'b1;
                if (i_st.red_last) begin
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                o_cmd.rd_a = 1'b1;
                n_state    = S_RDB;
            end
            S_RDB: begin
                o_cmd.rd_b = 1'b1;
                n_state    = S_DEC;
            end
            S_DEC: begin
                o_cmd.dec = 1'b1;
                unique case (i_st.act_now)
                    ACT_NEW, ACT_A_JOINED: n_state = S_WRA;
                    ACT_B_JOINED:          n_state = S_WRB;
                    ACT_RELABEL:           n_state = S_SCAN;
                    default:               n_state = S_DONE;
                endcase
            end
            S_WRA: begin
                o_cmd.wr_a = 1'b1;
                n_state    = (i_st.act_reg == ACT_NEW) ? S_WRB : S_DONE;
            end
            S_WRB: begin
                o_cmd.wr_b = 1'b1;
                n_state    = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_st.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/clmt_dp.sv
`timescale 1ns / 1ps

module clmt_dp import clmt_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_st             o_st,
    input  logic               i_cfg_valid,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic [TDATA_W-1:0] i_s_tdata,
    input  logic               i_s_tuser,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata,
    output logic [ACT_W-1:0]   o_m_tuser
);

    // Indices only reach 1024 entries, so a larger table is never addressed past that.
    localparam bit NEED_RED = (ENTRIES < (1 << IDX_IN_W));
    localparam int DEPTH    = NEED_RED ? ENTRIES : (1 << IDX_IN_W);
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int K_W      = $clog2(DEPTH + 1);

    // Reciprocal for the index reduction: floor(x * RECIP_M >> RECIP_S) is x / ENTRIES
    // for every 10-bit x.
    localparam int P_W      = 2 * IDX_IN_W + 2;
    localparam int RED_DI   = NEED_RED ? ENTRIES : 2;
    localparam int RECIP_S  = IDX_IN_W + $clog2(RED_DI);
    localparam int RECIP_MI = ((1 << RECIP_S) + RED_DI - 1) / RED_DI;

    localparam logic [IDX_IN_W-1:0] RED_D   = IDX_IN_W'(RED_DI);
    localparam logic [P_W-1:0]      RECIP_M = P_W'(RECIP_MI);
    localparam logic [K_W-1:0]      DEPTH_K = K_W'(DEPTH);
    localparam logic [K_W-1:0]      LAST_K  = K_W'(DEPTH - 1);
    localparam logic [CFG_W-1:0]    DEPTH_C = CFG_W'(DEPTH);

    logic                r_cmd;
    logic [IDX_IN_W-1:0] r_a;
    logic [IDX_IN_W-1:0] r_b;
    logic                r_red_ph;
    logic [P_W-1:0]      r_pa;
    logic [P_W-1:0]      r_pb;
    logic [LABEL_W-1:0]  r_la;
    logic [LABEL_W-1:0]  r_lb;
    t_action             r_act;
    logic [LABEL_W-1:0]  r_next;
    logic [CFG_W-1:0]    r_limit;
    logic [K_W-1:0]      r_k;
    logic [IDX_W-1:0]    r_pk;
    logic                r_pv;
    logic [LABEL_W-1:0]  r_q;
    logic                r_ovalid;
    logic [LABEL_W-1:0]  r_o_la;
    logic [LABEL_W-1:0]  r_o_lb;
    t_action             r_o_act;

    logic [LABEL_W-1:0]  mem [DEPTH];

    logic [IDX_IN_W-1:0] quo_a;
    logic [IDX_IN_W-1:0] quo_b;
    logic [IDX_IN_W-1:0] n_a;
    logic [IDX_IN_W-1:0] n_b;
    logic [IDX_W-1:0]    a_idx;
    logic [IDX_W-1:0]    b_idx;
    logic [IDX_W-1:0]    k_idx;
    logic [K_W-1:0]      scan_lim;
    logic                scan_more;
    logic [IDX_W-1:0]    rd_addr;
    logic                we;
    logic [IDX_W-1:0]    wa;
    logic [LABEL_W-1:0]  wd;
    t_action             act_now;
    logic                out_free;

    assign a_idx    = r_a[IDX_W-1:0];
    assign b_idx    = r_b[IDX_W-1:0];
    assign k_idx    = r_k[IDX_W-1:0];
    assign scan_lim = (r_limit > DEPTH_C) ? DEPTH_K : r_limit[K_W-1:0];
    assign scan_more = (r_k < scan_lim);
    assign out_free = !r_ovalid || i_m_tready;

    // Remainder from the registered reciprocal products: index minus quotient times ENTRIES.
    assign quo_a = IDX_IN_W'(r_pa >> RECIP_S);
    assign quo_b = IDX_IN_W'(r_pb >> RECIP_S);
    assign n_a   = r_a - quo_a * RED_D;
    assign n_b   = r_b - quo_b * RED_D;

    // Case decision from the label of A and the label of B on the read port.
    always_comb begin
        priority if (r_cmd == CMD_READ) begin
            act_now = ACT_NONE;
        end else if (r_la == '0 && r_q == '0) begin
            act_now = ACT_NEW;
        end else if (r_la != '0 && r_q == '0) begin
            act_now = ACT_B_JOINED;
        end else if (r_la == '0 && r_q != '0) begin
            act_now = ACT_A_JOINED;
        end else if (r_la != r_q) begin
            act_now = ACT_RELABEL;
        end else begin
            act_now = ACT_NONE;
        end
    end

    // Read address select.
    always_comb begin
        priority if (i_cmd.rd_a) begin
            rd_addr = a_idx;
        end else if (i_cmd.rd_b) begin
            rd_addr = b_idx;
        end else if (i_cmd.scan_step && scan_more) begin
            rd_addr = k_idx;
        end else begin
            rd_addr = a_idx;
        end
    end

    // Write port select: clearing pass, merge writes, relabel writes.
    always_comb begin
        we = 1'b0;
        wa = '0;
        wd = '0;
        priority if (i_cmd.clr_step) begin
            we = 1'b1;
            wa = k_idx;
        end else if (i_cmd.wr_a) begin
            we = 1'b1;
            wa = a_idx;
            wd = r_la;
        end else if (i_cmd.wr_b) begin
            we = 1'b1;
            wa = b_idx;
            wd = r_lb;
        end else if (i_cmd.scan_step && r_pv && (r_q == r_la)) begin
            we = 1'b1;
            wa = r_pk;
            wd = r_lb;
        end
    end

    // Label table with one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_q <= mem[rd_addr];
    end

    // Request payload, reduction and label bookkeeping.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= i_s_tuser;
            r_a      <= i_s_tdata[IDX_IN_W-1:0];
            r_b      <= i_s_tdata[2*IDX_IN_W-1:IDX_IN_W];
            r_red_ph <= 1'b0;
        end else if (i_cmd.red_step) begin
            if (!r_red_ph) begin
                r_pa     <= P_W'(r_a) * RECIP_M;
                r_pb     <= P_W'(r_b) * RECIP_M;
                r_red_ph <= 1'b1;
            end else begin
                r_a <= n_a;
                r_b <= n_b;
            end
        end
        if (i_cmd.rd_b) begin
            r_la <= r_q;
        end
        if (i_cmd.dec) begin
            r_act <= act_now;
            unique case (act_now)
                ACT_NEW: begin
                    r_la <= r_next;
                    r_lb <= r_next;
                end
                ACT_B_JOINED: r_lb <= r_la;
                ACT_A_JOINED: begin
                    r_la <= r_q;
                    r_lb <= r_q;
                end
                ACT_RELABEL:  r_lb <= r_q;
                default:      r_lb <= (r_cmd == CMD_READ) ? '0 : r_q;
            endcase
        end
    end

    // Control state: allocator, scan limit, scan and clear counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next  <= LABEL_W'(1);
            r_limit <= CFG_W'(1 << IDX_IN_W);
            r_k     <= '0;
            r_pv    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.dec && act_now == ACT_NEW && r_next != LABEL_MAX) begin
                r_next <= r_next + 1'b1;
            end
            if (i_cmd.dec) begin
                r_k  <= '0;
                r_pv <= 1'b0;
            end else if (i_cmd.clr_step) begin
                r_k <= r_k + 1'b1;
            end else if (i_cmd.scan_step) begin
                r_pv <= scan_more;
                if (scan_more) begin
                    r_pk <= k_idx;
                    r_k  <= r_k + 1'b1;
                end
            end
        end
    end

    // Output register; A outside the scan keeps its old label after a relabel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_o_la  <= (r_act == ACT_RELABEL && K_W'(a_idx) < scan_lim) ? r_lb : r_la;
            r_o_lb  <= r_lb;
            r_o_act <= r_act;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{(TDATA_W - 2 * LABEL_W){1'b0}}, r_o_lb, r_o_la};
    assign o_m_tuser  = r_o_act;

    assign o_st.red_last  = !NEED_RED || r_red_ph;
    assign o_st.clr_last  = (r_k == LAST_K);
    assign o_st.scan_done = !scan_more && !r_pv;
    assign o_st.out_free  = out_free;
    assign o_st.act_now   = act_now;
    assign o_st.act_reg   = r_act;

`ifndef SYNTH
    // The allocator never hands out the unclustered label.
    a_next_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next != '0)
        else $error("label allocator reached zero");

    // A result is never loaded over one that has not been taken.
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("result register overwritten");

    // The allocator moves only when a new cluster is formed.
    a_next_moves_on_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_next != $past(r_next))
            |-> ($past(i_cmd.dec) && $past(act_now) == ACT_NEW))
        else $error("label allocator moved without a new cluster");
`endif

endmodule
